>>> src/merge_sort_batch_core_assert.svh
// Assertion macros for the merge sort batch core.
`ifndef MERGE_SORT_BATCH_CORE_ASSERT_SVH
`define MERGE_SORT_BATCH_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MSB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MSB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/msb_pkg.sv
// Shared constants and types of the merge sort batch core.
package msb_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int STORE_DEPTH = 64;
    localparam int VALUE_W     = 32;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int IDX_W       = CNT_W + 1;

    typedef logic signed [VALUE_W-1:0] t_value;

endpackage

>>> src/msb_stream_if.sv
// Valid/ready stream interfaces for requests and sorted results.
interface msb_in_if import msb_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value value;
    logic   last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface msb_out_if import msb_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value value_res;
    logic   last_res;
    logic   overflow;

    modport source (output valid, output value_res, output last_res, output overflow,
                    input ready);
    modport sink   (input valid, input value_res, input last_res, input overflow,
                    output ready);
endinterface

>>> src/msb_ram.sv
// Generic RAM: one write port, two registered read ports.
module msb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> src/merge_sort_batch_core.sv
// Batch merge sort core: load, bottom-up merge passes over two RAMs, drain.
// A batch of n requests is loaded, then sorted in ceil(log2 n) passes, each opened by
// a TURN state (one merged element per cycle through the dual-read RAM); a PRIME state
// presents the first sorted entry, then one result per cycle while the result register is free or being taken.
// A new batch is accepted only after the last result of the current one is registered.
// Reset (synchronous, active low) clears state, count, drop flag and result valid.
module merge_sort_batch_core import msb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    msb_in_if.sink    i_in,
    msb_out_if.source o_out
);

    `include "merge_sort_batch_core_assert.svh"

    // LOAD: take requests. TURN: present run heads before a pass.
    // MERGE: one output element per cycle. PRIME: present first sorted entry.
    // DRAIN: stream sorted entries into the result register.
    typedef enum logic [2:0] {
        S_LOAD,
        S_TURN,
        S_MERGE,
        S_PRIME,
        S_DRAIN
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;    // elements held in the batch
    logic               r_drop,  n_drop;   // a request was dropped in this batch
    logic [CNT_W-1:0]   r_width, n_width;  // run width of the current pass
    logic [CNT_W-1:0]   r_i,     n_i;      // left run head; read index while draining
    logic [CNT_W-1:0]   r_j,     n_j;      // right run head
    logic [CNT_W-1:0]   r_mid,   n_mid;    // end of left run
    logic [CNT_W-1:0]   r_hi,    n_hi;     // end of right run
    logic [CNT_W-1:0]   r_k,     n_k;      // write index into destination RAM
    logic               r_src,   n_src;    // RAM holding the current runs

    logic               r_o_valid, n_o_valid;
    t_value             r_o_value, n_o_value;
    logic               r_o_last,  n_o_last;
    logic               r_o_ovf,   n_o_ovf;

    // RAM ports
    logic               w0_en, w1_en;
    logic [ADDR_W-1:0]  w_addr;
    t_value             w_data;
    t_value             rd0_a, rd0_b, rd1_a, rd1_b;
    t_value             rd_l, rd_r;

    logic               take_left;
    logic [CNT_W-1:0]   k_nxt;
    logic [CNT_W-1:0]   cnt_inc;
    logic [CNT_W-1:0]   batch_n;
    logic [IDX_W-1:0]   wid2;
    logic [IDX_W-1:0]   lo_ext;
    logic               drain_load;
    logic               drain_last;

    function automatic logic [CNT_W-1:0] clamp_cnt(input logic [IDX_W-1:0] a,
                                                   input logic [CNT_W-1:0] n);
        logic [IDX_W-1:0] n_ext;
        n_ext = {1'b0, n};
        return (a < n_ext) ? a[CNT_W-1:0] : n;
    endfunction

    // Both RAMs read at the next head indices, so in the following cycle the registered read
    // data matches the head registers unless that entry was written in the same cycle.
    msb_ram #(.WIDTH(VALUE_W), .DEPTH(STORE_DEPTH)) u_ram0 (
        .i_clk     (i_clk),
        .i_we      (w0_en),
        .i_waddr   (w_addr),
        .i_wdata   (w_data),
        .i_raddr_a (n_i[ADDR_W-1:0]),
        .i_raddr_b (n_j[ADDR_W-1:0]),
        .o_rdata_a (rd0_a),
        .o_rdata_b (rd0_b)
    );

    msb_ram #(.WIDTH(VALUE_W), .DEPTH(STORE_DEPTH)) u_ram1 (
        .i_clk     (i_clk),
        .i_we      (w1_en),
        .i_waddr   (w_addr),
        .i_wdata   (w_data),
        .i_raddr_a (n_i[ADDR_W-1:0]),
        .i_raddr_b (n_j[ADDR_W-1:0]),
        .o_rdata_a (rd1_a),
        .o_rdata_b (rd1_b)
    );

    assign rd_l = r_src ? rd1_a : rd0_a;
    assign rd_r = r_src ? rd1_b : rd0_b;

    // Left run wins ties; an exhausted run never wins.
    assign take_left = (r_i < r_mid) && ((r_j >= r_hi) || (rd_l <= rd_r));
    assign k_nxt     = r_k + CNT_W'(1);
    assign cnt_inc   = r_cnt + CNT_W'(1);
    assign wid2      = {r_width, 1'b0};
    assign lo_ext    = {1'b0, r_hi};

    assign drain_load = (!r_o_valid) || o_out.ready;
    assign drain_last = ((r_i + CNT_W'(1)) == r_cnt);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_drop    = r_drop;
        n_width   = r_width;
        n_i       = r_i;
        n_j       = r_j;
        n_mid     = r_mid;
        n_hi      = r_hi;
        n_k       = r_k;
        n_src     = r_src;
        n_o_valid = r_o_valid && !o_out.ready;
        n_o_value = r_o_value;
        n_o_last  = r_o_last;
        n_o_ovf   = r_o_ovf;
        w0_en     = 1'b0;
        w1_en     = 1'b0;
        w_addr    = r_k[ADDR_W-1:0];
        w_data    = rd_l;
        batch_n   = r_cnt;

        unique case (r_state)
            S_LOAD: begin
                if (i_in.valid) begin
                    // Store while there is room, else drop and flag the batch.
                    if (r_cnt < CNT_W'(MAX_ITEMS)) begin
                        w0_en   = 1'b1;
                        w_addr  = r_cnt[ADDR_W-1:0];
                        w_data  = i_in.value;
                        n_cnt   = cnt_inc;
                        batch_n = cnt_inc;
                    end else begin
                        n_drop  = 1'b1;
                    end
                    if (i_in.last) begin
                        n_src = 1'b0;
                        n_i   = '0;
                        if (batch_n > CNT_W'(1)) begin
                            // First pass: runs of width one.
                            n_width = CNT_W'(1);
                            n_mid   = CNT_W'(1);
                            n_j     = CNT_W'(1);
                            n_hi    = CNT_W'(2);
                            n_k     = '0;
                            n_state = S_TURN;
                        end else begin
                            n_state = S_PRIME;
                        end
                    end
                end
            end

            S_TURN: begin
                n_state = S_MERGE;
            end

            S_MERGE: begin
                w_data = take_left ? rd_l : rd_r;
                if (r_src) begin
                    w0_en = 1'b1;
                end else begin
                    w1_en = 1'b1;
                end
                if (take_left) begin
                    n_i = r_i + CNT_W'(1);
                end else begin
                    n_j = r_j + CNT_W'(1);
                end
                if (k_nxt == r_hi) begin
                    if (r_hi == r_cnt) begin
                        // Pass done: swap RAM roles, double the width or finish.
                        n_src = !r_src;
                        n_i   = '0;
                        if (wid2 < {1'b0, r_cnt}) begin
                            n_width = wid2[CNT_W-1:0];
                            n_mid   = clamp_cnt(wid2, r_cnt);
                            n_j     = clamp_cnt(wid2, r_cnt);
                            n_hi    = clamp_cnt(wid2 << 1, r_cnt);
                            n_k     = '0;
                            n_state = S_TURN;
                        end else begin
                            n_state = S_PRIME;
                        end
                    end else begin
                        // Next pair of runs starts where this one ended.
                        n_i   = r_hi;
                        n_mid = clamp_cnt(lo_ext + {1'b0, r_width}, r_cnt);
                        n_j   = clamp_cnt(lo_ext + {1'b0, r_width}, r_cnt);
                        n_hi  = clamp_cnt(lo_ext + wid2, r_cnt);
                        n_k   = k_nxt;
                    end
                end else begin
                    n_k = k_nxt;
                end
            end

            S_PRIME: begin
                n_state = S_DRAIN;
            end

            S_DRAIN: begin
                // Advance only when the result register is free or being taken.
                if (drain_load) begin
                    n_o_valid = 1'b1;
                    n_o_value = rd_l;
                    n_o_last  = drain_last;
                    n_o_ovf   = r_drop;
                    n_i       = r_i + CNT_W'(1);
                    if (drain_last) begin
                        n_cnt   = '0;
                        n_drop  = 1'b0;
                        n_state = S_LOAD;
                    end
                end
            end

            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_cnt     <= '0;
            r_drop    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_drop    <= n_drop;
            r_o_valid <= n_o_valid;
        end
        r_width   <= n_width;
        r_i       <= n_i;
        r_j       <= n_j;
        r_mid     <= n_mid;
        r_hi      <= n_hi;
        r_k       <= n_k;
        r_src     <= n_src;
        r_o_value <= n_o_value;
        r_o_last  <= n_o_last;
        r_o_ovf   <= n_o_ovf;
    end

    assign i_in.ready      = (r_state == S_LOAD);
    assign o_out.valid     = r_o_valid;
    assign o_out.value_res = r_o_value;
    assign o_out.last_res  = r_o_last;
    assign o_out.overflow  = r_o_ovf;

    `MSB_ASSERT_NOW(a_cnt_cap, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(MAX_ITEMS),
        "element count exceeds capacity")
    `MSB_ASSERT_NOW(a_merge_bounds, i_clk, i_rst_n, r_state == S_MERGE,
        (r_k < r_hi) && (r_hi <= r_cnt) && (r_i <= r_mid) && (r_j <= r_hi),
        "merge indices out of run bounds")
    `MSB_ASSERT_NEXT(a_batch_end, i_clk, i_rst_n,
        (r_state == S_DRAIN) && drain_load && drain_last,
        (r_state == S_LOAD) && (r_cnt == '0) && !r_drop && r_o_last,
        "batch did not close after its last result")
endmodule
